// File: design/thermal_frame_deframer_top_assert.svh
// Assertion macros for the thermal frame deframer checker.
// Depends on nothing; included by the checker file only.
`ifndef THERMAL_FRAME_DEFRAMER_TOP_ASSERT_SVH
`define THERMAL_FRAME_DEFRAMER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TFD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("deframer check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define TFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("deframer check failed one cycle later");

`endif

// File: design/tfd_pkg.sv
// Shared types and constants of the thermal frame deframer.
// Depends on nothing; used by all modules and by the testbench.
`timescale 1ns / 1ps
`default_nettype none
package tfd_pkg;

	// Configuration register indexes.
	localparam logic [1:0] CFG_PIXEL_OFFSET  = 2'd0;
	localparam logic [1:0] CFG_PIXEL_COUNT   = 2'd1;
	localparam logic [1:0] CFG_KELVIN_OFFSET = 2'd2;

	localparam int CFG_DATA_W = 16;

	localparam logic [11:0]        RST_PIXEL_OFFSET  = 12'd320;
	localparam logic [14:0]        RST_PIXEL_COUNT   = 15'd4960;
	localparam logic signed [15:0] RST_KELVIN_OFFSET = -16'sd27315;

	// Result kinds.
	localparam logic KIND_PIXEL  = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// Frame status codes.
	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_MISMATCH = 2'd1;
	localparam logic [1:0] ERR_NOT_HEX  = 2'd2;
	localparam logic [1:0] ERR_SHORT    = 2'd3;

	localparam logic [3:0] BAD_RUN_MAX = 4'd15;

	typedef struct packed {
		logic [11:0]        pixel_offset;
		logic [14:0]        pixel_count;
		logic signed [15:0] kelvin_offset;
	} tfd_cfg_t;

	// One classified result waiting for the back end.
	typedef struct packed {
		logic        kind;
		logic [14:0] pixel_index;
		logic [15:0] raw_value;
		logic [1:0]  error_code;
	} tfd_entry_t;

endpackage
`default_nettype wire

// File: design/tfd_if.sv
// Handshake channels of the thermal frame deframer: byte input and result output.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface tfd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface tfd_result_if;
	logic               valid;
	logic               ready;
	logic               result_kind;
	logic [14:0]        pixel_index;
	logic [15:0]        raw_value;
	logic signed [20:0] temperature_centi;
	logic               frame_good;
	logic [1:0]         error_code;
	logic [3:0]         bad_run;

	modport source (output valid, output result_kind, output pixel_index, output raw_value,
		output temperature_centi, output frame_good, output error_code, output bad_run,
		input ready);
	modport sink (input valid, input result_kind, input pixel_index, input raw_value,
		input temperature_centi, input frame_good, input error_code, input bad_run,
		output ready);
endinterface
`default_nettype wire

// File: design/tfd_front.sv
// Front end of the deframer: sync hunt, length and body parsing, checksum tracking.
// Depends on tfd_pkg; pushes one entry per producing byte into tfd_fifo.
`timescale 1ns / 1ps
`default_nettype none
module tfd_front (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  wire [7:0]         data_byte,
	input  tfd_pkg::tfd_cfg_t cfg,
	input  wire               fifo_full,
	output logic              push,
	output tfd_pkg::tfd_entry_t entry
);

	localparam logic [1:0] PH_HUNT = 2'd0;
	localparam logic [1:0] PH_LEN  = 2'd1;
	localparam logic [1:0] PH_BODY = 2'd2;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;

	logic [1:0]  phase_q;
	logic [1:0]  sync_q;
	logic [15:0] body_length_q;
	logic [15:0] byte_position_q;
	logic        command_ok_q;
	logic [15:0] running_sum_q;
	logic [15:0] expected_sum_q;
	logic        hex_bad_q;
	logic [7:0]  low_hold_q;
	logic [14:0] pixel_counter_q;

	// Returns {ok, value}.
	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) r = {1'b1, b[3:0]};
		else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
			r = {1'b1, b[3:0] + 4'd9};
		return r;
	endfunction

	function automatic logic [7:0] cmd_tag(input logic [1:0] i);
		logic [7:0] c;
		case (i)
			2'd0: c = 8'h47;
			2'd1: c = 8'h46;
			2'd2: c = 8'h52;
			default: c = 8'h41;
		endcase
		return c;
	endfunction

	logic        accept;
	logic [4:0]  hex;
	logic        len_ge8;
	logic [15:0] len_m4;
	logic [12:0] start;
	logic [15:0] span;
	logic [16:0] end_pos;
	logic        fits;
	logic [16:0] rel;
	logic        in_window;
	logic        cmd_ok_next;
	logic        in_sum_region;
	logic [15:0] expected_next;
	logic        hex_bad_next;
	logic        last_byte;
	logic        pixel_fire;
	logic        status_fire;
	logic [1:0]  sync_base;

	assign in_ready = !fifo_full;
	assign accept   = in_valid && in_ready;
	assign hex      = hex_digit(data_byte);

	assign len_ge8       = body_length_q >= 16'd8;
	assign len_m4        = body_length_q - 16'd4;
	assign start         = {1'b0, cfg.pixel_offset} + 13'd4;
	assign span          = {cfg.pixel_count, 1'b0};
	assign end_pos       = 17'(start) + 17'(span);
	assign fits          = len_ge8 && (end_pos <= 17'(len_m4));
	assign rel           = 17'(byte_position_q) - 17'(start);
	assign in_window     = (byte_position_q >= 16'(start)) && (rel < 17'(span));
	assign in_sum_region = byte_position_q < len_m4;

	assign cmd_ok_next = command_ok_q &&
		!((byte_position_q < 16'd4) && (data_byte != cmd_tag(byte_position_q[1:0])));

	assign hex_bad_next  = hex_bad_q || (len_ge8 && !in_sum_region && !hex[4]);
	assign expected_next = (len_ge8 && !in_sum_region) ? {expected_sum_q[11:0], hex[3:0]}
		: expected_sum_q;
	assign last_byte     = (17'(byte_position_q) + 17'd1) >= 17'(body_length_q);

	assign pixel_fire  = (phase_q == PH_BODY) && command_ok_q && (byte_position_q >= 16'd4)
		&& fits && in_window && rel[0];
	assign status_fire = (phase_q == PH_BODY) && last_byte && cmd_ok_next;

	assign push = accept && (pixel_fire || status_fire);

	always_comb begin
		entry = '0;
		if (status_fire) begin
			entry.kind = tfd_pkg::KIND_STATUS;
			if (hex_bad_next) entry.error_code = tfd_pkg::ERR_NOT_HEX;
			else if (running_sum_q != expected_next) entry.error_code = tfd_pkg::ERR_MISMATCH;
			else if (!fits) entry.error_code = tfd_pkg::ERR_SHORT;
			else entry.error_code = tfd_pkg::ERR_NONE;
		end else begin
			entry.kind        = tfd_pkg::KIND_PIXEL;
			entry.pixel_index = pixel_counter_q;
			entry.raw_value   = {data_byte, low_hold_q};
		end
	end

	// A rejected length digit is fed to the hunt with the match count cleared.
	assign sync_base = (phase_q == PH_LEN) ? 2'd0 : sync_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_HUNT;
			sync_q          <= 2'd0;
			body_length_q   <= 16'd0;
			byte_position_q <= 16'd0;
			command_ok_q    <= 1'b0;
			running_sum_q   <= 16'd0;
			expected_sum_q  <= 16'd0;
			hex_bad_q       <= 1'b0;
			low_hold_q      <= 8'd0;
			pixel_counter_q <= 15'd0;
		end else if (accept) begin
			if (phase_q == PH_LEN && hex[4]) begin
				body_length_q   <= {body_length_q[11:0], hex[3:0]};
				running_sum_q   <= running_sum_q + 16'(data_byte);
				if (byte_position_q[1:0] == 2'd3) begin
					byte_position_q <= 16'd0;
					expected_sum_q  <= 16'd0;
					hex_bad_q       <= 1'b0;
					pixel_counter_q <= 15'd0;
					low_hold_q      <= 8'd0;
					command_ok_q    <= {body_length_q[11:0], hex[3:0]} >= 16'd8;
					phase_q <= ({body_length_q[11:0], hex[3:0]} == 16'd0) ? PH_HUNT : PH_BODY;
				end else begin
					byte_position_q <= byte_position_q + 16'd1;
				end
			end else if (phase_q == PH_BODY) begin
				if (len_ge8 && in_sum_region) running_sum_q <= running_sum_q + 16'(data_byte);
				expected_sum_q <= expected_next;
				hex_bad_q      <= hex_bad_next;
				if (command_ok_q && (byte_position_q >= 16'd4) && fits && in_window) begin
					if (!rel[0]) low_hold_q <= data_byte;
					else pixel_counter_q <= pixel_counter_q + 15'd1;
				end
				if (last_byte) begin
					phase_q         <= PH_HUNT;
					sync_q          <= 2'd0;
					byte_position_q <= 16'd0;
					command_ok_q    <= 1'b0;
				end else begin
					command_ok_q    <= cmd_ok_next;
					byte_position_q <= byte_position_q + 16'd1;
				end
			end else begin
				if (data_byte == CH_SPACE) begin
					phase_q <= PH_HUNT;
					sync_q  <= (sync_base == 2'd3) ? sync_base : sync_base + 2'd1;
				end else if (data_byte == CH_HASH && sync_base == 2'd3) begin
					phase_q         <= PH_LEN;
					sync_q          <= 2'd0;
					byte_position_q <= 16'd0;
					body_length_q   <= 16'd0;
					running_sum_q   <= 16'd0;
				end else begin
					phase_q <= PH_HUNT;
					sync_q  <= 2'd0;
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: design/tfd_fifo.sv
// Four-entry queue between the deframer front and back ends.
// Depends on tfd_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none
module tfd_fifo (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  tfd_pkg::tfd_entry_t push_entry,
	output logic                full,
	input  wire                 pop,
	output logic                not_empty,
	output tfd_pkg::tfd_entry_t head
);

	tfd_pkg::tfd_entry_t mem_q [4];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign full      = count_q == 3'd4;
	assign not_empty = count_q != 3'd0;
	assign head      = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 2'd1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 2'd1;
			if (do_push && !do_pop) count_q <= count_q + 3'd1;
			else if (do_pop && !do_push) count_q <= count_q - 3'd1;
		end
	end

endmodule
`default_nettype wire

// File: design/tfd_back.sv
// Back end of the deframer: temperature scaling, bad-frame run, output register.
// Depends on tfd_pkg; pops entries from tfd_fifo.
`timescale 1ns / 1ps
`default_nettype none
module tfd_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  tfd_pkg::tfd_cfg_t   cfg,
	input  wire                 not_empty,
	input  tfd_pkg::tfd_entry_t head,
	output logic                pop,
	tfd_result_if.source        res
);

	logic               valid_q;
	logic [3:0]         bad_run_q;
	logic               kind_q;
	logic [14:0]        index_q;
	logic [15:0]        raw_q;
	logic signed [20:0] temp_q;
	logic               good_q;
	logic [1:0]         err_q;

	logic [19:0]        raw_x10;
	logic [20:0]        temp_sum;
	logic               good;
	logic [3:0]         bad_run_next;

	assign pop = not_empty && (!valid_q || res.ready);

	// Ten times raw as two shifted copies; the offset is sign-extended.
	assign raw_x10  = {1'b0, head.raw_value, 3'b000} + {3'b000, head.raw_value, 1'b0};
	assign temp_sum = {1'b0, raw_x10} + {{5{cfg.kelvin_offset[15]}}, cfg.kelvin_offset};
	assign good     = head.error_code == tfd_pkg::ERR_NONE;
	assign bad_run_next = good ? 4'd0
		: ((bad_run_q == tfd_pkg::BAD_RUN_MAX) ? bad_run_q : bad_run_q + 4'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			bad_run_q <= 4'd0;
		end else begin
			if (pop) valid_q <= 1'b1;
			else if (res.ready) valid_q <= 1'b0;
			if (pop && head.kind == tfd_pkg::KIND_STATUS) bad_run_q <= bad_run_next;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q <= head.kind;
			if (head.kind == tfd_pkg::KIND_STATUS) begin
				index_q <= 15'd0;
				raw_q   <= 16'd0;
				temp_q  <= 21'sd0;
				good_q  <= good;
				err_q   <= head.error_code;
			end else begin
				index_q <= head.pixel_index;
				raw_q   <= head.raw_value;
				temp_q  <= signed'(temp_sum);
				good_q  <= 1'b0;
				err_q   <= tfd_pkg::ERR_NONE;
			end
		end
	end

	assign res.valid             = valid_q;
	assign res.result_kind       = kind_q;
	assign res.pixel_index       = index_q;
	assign res.raw_value         = raw_q;
	assign res.temperature_centi = temp_q;
	assign res.frame_good        = good_q;
	assign res.error_code        = err_q;
	assign res.bad_run           = (kind_q == tfd_pkg::KIND_STATUS) ? bad_run_q : 4'd0;

endmodule
`default_nettype wire

// File: design/thermal_frame_deframer_top.sv
// Thermal frame deframer: one byte accepted per cycle while the result queue has room.
// The entry a byte causes goes through the four-entry queue into the output register.
// Sustained rate is one byte per cycle while the queue can absorb output stalls.
// Reset is asynchronous and active low: the parser returns to the sync hunt, the queue
// and output empty, the bad-frame run clears and the registers take their reset values.
// Depends on tfd_pkg, tfd_if, tfd_front, tfd_fifo and tfd_back.
`timescale 1ns / 1ps
`default_nettype none
module thermal_frame_deframer_top (
	input  wire                            clk,
	input  wire                            arst_n,
	tfd_byte_if.sink                       byte_ch,
	tfd_result_if.source                   result_ch,
	input  wire                            cfg_write,
	input  wire [1:0]                      cfg_index,
	input  wire [tfd_pkg::CFG_DATA_W-1:0]  cfg_data
);

	// Configuration registers, read directly by both ends. Writes must come only while no
	// frame work is pending, up to the user; it is not enforced. Index three is ignored.
	tfd_pkg::tfd_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_offset  <= tfd_pkg::RST_PIXEL_OFFSET;
			cfg_q.pixel_count   <= tfd_pkg::RST_PIXEL_COUNT;
			cfg_q.kelvin_offset <= tfd_pkg::RST_KELVIN_OFFSET;
		end else if (cfg_write) begin
			case (cfg_index)
				tfd_pkg::CFG_PIXEL_OFFSET:  cfg_q.pixel_offset  <= cfg_data[11:0];
				tfd_pkg::CFG_PIXEL_COUNT:   cfg_q.pixel_count   <= cfg_data[14:0];
				tfd_pkg::CFG_KELVIN_OFFSET: cfg_q.kelvin_offset <= signed'(cfg_data);
				default: ;
			endcase
		end
	end

	// The front end parses every byte in the cycle it is accepted. Only bytes that
	// complete a pixel or end a good-command frame push an item into the queue;
	// the front end stalls only when the queue is full.
	logic                fifo_full;
	logic                push;
	tfd_pkg::tfd_entry_t push_entry;
	logic                pop;
	logic                not_empty;
	tfd_pkg::tfd_entry_t head;

	tfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (byte_ch.valid),
		.in_ready  (byte_ch.ready),
		.data_byte (byte_ch.data_byte),
		.cfg       (cfg_q),
		.fifo_full (fifo_full),
		.push      (push),
		.entry     (push_entry)
	);

	tfd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (fifo_full),
		.pop        (pop),
		.not_empty  (not_empty),
		.head       (head)
	);

	// The back end scales pixels to hundredths of a degree, keeps the saturating
	// count of bad frames, and holds each result in the output register until taken.
	tfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.not_empty (not_empty),
		.head      (head),
		.pop       (pop),
		.res       (result_ch)
	);

endmodule
`default_nettype wire

// File: design/tfd_checker.sv
// Port-level checks of the thermal frame deframer, bound to its top level.
// Depends on tfd_pkg and thermal_frame_deframer_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "thermal_frame_deframer_top_assert.svh"
module tfd_checker (
	input wire               clk,
	input wire               arst_n,
	input wire               out_valid,
	input wire               out_ready,
	input wire               result_kind,
	input wire [14:0]        pixel_index,
	input wire [15:0]        raw_value,
	input wire signed [20:0] temperature_centi,
	input wire               frame_good,
	input wire [1:0]         error_code,
	input wire [3:0]         bad_run
);

	logic is_status;
	logic is_pixel;

	assign is_status = out_valid && (result_kind == tfd_pkg::KIND_STATUS);
	assign is_pixel  = out_valid && (result_kind == tfd_pkg::KIND_PIXEL);

	`TFD_ASSERT_IMPLY(a_status_no_pixel, clk, arst_n, is_status, (pixel_index == 15'd0) && (raw_value == 16'd0) && (temperature_centi == 21'sd0))
	`TFD_ASSERT_IMPLY(a_status_good_run, clk, arst_n, is_status, (frame_good == (error_code == tfd_pkg::ERR_NONE)) && (frame_good == (bad_run == 4'd0)))
	`TFD_ASSERT_IMPLY(a_pixel_no_status, clk, arst_n, is_pixel, !frame_good && (error_code == tfd_pkg::ERR_NONE) && (bad_run == 4'd0))
	`TFD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(raw_value) && $stable(error_code) && $stable(pixel_index))

endmodule

bind thermal_frame_deframer_top tfd_checker u_tfd_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (result_ch.valid),
	.out_ready         (result_ch.ready),
	.result_kind       (result_ch.result_kind),
	.pixel_index       (result_ch.pixel_index),
	.raw_value         (result_ch.raw_value),
	.temperature_centi (result_ch.temperature_centi),
	.frame_good        (result_ch.frame_good),
	.error_code        (result_ch.error_code),
	.bad_run           (result_ch.bad_run)
);
`default_nettype wire

// File: dv/thermal_frame_deframer_top_test.sv
// Self-checking testbench of the thermal frame deframer: framed byte streams go in, and
// pixel and frame status items are checked against an in-bench model of the parser.
// Depends on tfd_pkg, the tfd_if channel interfaces and thermal_frame_deframer_top.
`timescale 1ns / 1ps
module thermal_frame_deframer_top_test;

	// Cycles without any accepted item before the run is declared hung. The longest
	// legitimate quiet stretch is the forced receiver hold-off of HOLD_CYCLES.
	localparam int WATCHDOG_LIMIT = 4000;
	// An item reaches the output register through the queue; this leaves ample margin for
	// bytes that make no item before the registers are touched or the run ends.
	localparam int SETTLE_CYCLES  = 8;
	localparam int HOLD_CYCLES    = 300;
	// Bytes offered over the whole run, directed part included.
	localparam int TOTAL_BYTES    = 1750;
	localparam int RANDOM_PHASES  = 6;

	localparam logic [7:0] SYNC_SPACE = 8'h20;
	localparam logic [7:0] SYNC_HASH  = 8'h23;
	localparam logic [7:0] HASH_STANDIN = 8'h24;
	// Command tag of a frame that carries pixels: "GFRA".
	localparam logic [7:0] CMD_TAG [4] = '{8'h47, 8'h46, 8'h52, 8'h41};
	// The register port decodes two index bits; the last index names no register.
	localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;

	typedef enum logic [1:0] {SEEK_SYNC, READ_LENGTH, READ_BODY} parse_phase_t;
	typedef enum int {CK_GOOD, CK_WRONG, CK_NOT_HEX} checksum_mode_t;
	typedef enum int {FILL_RANDOM, FILL_ONES, FILL_EXTREMES} fill_kind_t;

	typedef struct {
		logic               result_kind;
		logic [14:0]        pixel_index;
		logic [15:0]        raw_value;
		logic signed [20:0] temperature_centi;
		logic               frame_good;
		logic [1:0]         error_code;
		logic [3:0]         bad_run;
	} frame_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_write;
	logic [1:0] cfg_index;
	logic [tfd_pkg::CFG_DATA_W-1:0] cfg_data;

	tfd_byte_if byte_ch();
	tfd_result_if result_ch();

	thermal_frame_deframer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_ch),
		.result_ch (result_ch),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Bytes waiting to be offered, and items the model says must come out, oldest first.
	logic [7:0] byte_q[$];
	frame_result_t expected_q[$];

	int fail_count = 0;
	int send_idle_pct = 7;
	int recv_idle_pct = 78;
	// Bumped by the stimulus to ask for one long receiver hold-off; the monitor keeps
	// its own copy so that only it ever writes the hold-off counter.
	int hold_order = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	// Every byte queued for the sender, the measure of how much stimulus was sent.
	int queued_bytes = 0;

	// Model of the parser: its state and its own copy of the registers.
	parse_phase_t       deframe_phase;
	int                 space_run;
	logic [15:0]        frame_len;
	logic [15:0]        body_pos;
	logic               cmd_match;
	logic [15:0]        byte_sum;
	logic [15:0]        sent_sum;
	logic               sum_digit_bad;
	logic [7:0]         low_hold;
	logic [14:0]        pixel_next;
	logic [3:0]         bad_frames;
	logic [11:0]        cfg_offset;
	logic [14:0]        cfg_count;
	logic signed [15:0] cfg_kelvin;

	// Bit 4 flags a hex digit; the low nibble is its value, zero for anything else.
	function automatic logic [4:0] hex_digit_value(input logic [7:0] b);
		if (b >= "0" && b <= "9")
			return {1'b1, 4'(b - "0")};
		if (b >= "A" && b <= "F")
			return {1'b1, 4'(b - "A" + 8'd10)};
		if (b >= "a" && b <= "f")
			return {1'b1, 4'(b - "a" + 8'd10)};
		return 5'd0;
	endfunction

	// The pixel run has to end before the four checksum digits of the body.
	function automatic bit pixels_fit_body();
		return 4 + int'(cfg_offset) + 2 * int'(cfg_count) <= int'(frame_len) - 4;
	endfunction

	// Sync hunt: three or more spaces followed by a hash opens the length field.
	task automatic hunt_sync(input logic [7:0] b);
		if (b == SYNC_SPACE) begin
			if (space_run < 3)
				space_run++;
		end else if (b == SYNC_HASH && space_run == 3) begin
			deframe_phase = READ_LENGTH;
			space_run = 0;
			body_pos = 0;
			frame_len = 0;
			byte_sum = 0;
		end else begin
			space_run = 0;
		end
	endtask

	// Advances the model by one accepted byte and queues the item it causes, if any.
	task automatic deframe_byte(input logic [7:0] b);
		logic [4:0] digit;
		int pos;
		int len;
		int first;
		int rel;
		logic [15:0] raw;
		int temp;
		logic [1:0] err;
		if (deframe_phase == READ_LENGTH) begin
			digit = hex_digit_value(b);
			if (!digit[4]) begin
				// A bad length digit drops back to the hunt, which then sees this byte.
				deframe_phase = SEEK_SYNC;
				space_run = 0;
				hunt_sync(b);
			end else begin
				frame_len = {frame_len[11:0], digit[3:0]};
				byte_sum += 16'(b);
				body_pos++;
				if (body_pos >= 4) begin
					body_pos = 0;
					sent_sum = 0;
					sum_digit_bad = 1'b0;
					pixel_next = 0;
					low_hold = 0;
					cmd_match = (frame_len >= 8);
					deframe_phase = (frame_len == 0) ? SEEK_SYNC : READ_BODY;
				end
			end
		end else if (deframe_phase != READ_BODY) begin
			hunt_sync(b);
		end else begin
			pos = body_pos;
			len = frame_len;
			if (pos < 4 && b != CMD_TAG[pos])
				cmd_match = 1'b0;
			if (len >= 8) begin
				if (pos < len - 4) begin
					byte_sum += 16'(b);
				end else begin
					digit = hex_digit_value(b);
					if (!digit[4])
						sum_digit_bad = 1'b1;
					sent_sum = {sent_sum[11:0], digit[3:0]};
				end
			end
			if (cmd_match && pos >= 4 && pixels_fit_body()) begin
				first = 4 + int'(cfg_offset);
				rel = pos - first;
				if (pos >= first && rel < 2 * int'(cfg_count)) begin
					if (!rel[0]) begin
						low_hold = b;
					end else begin
						raw = {b, low_hold};
						temp = int'(raw) * 10 + int'(cfg_kelvin);
						expected_q.push_back('{tfd_pkg::KIND_PIXEL, pixel_next, raw,
							temp[20:0], 1'b0, tfd_pkg::ERR_NONE, 4'd0});
						pixel_next++;
					end
				end
			end
			if (pos + 1 >= len) begin
				deframe_phase = SEEK_SYNC;
				space_run = 0;
				body_pos = 0;
				if (cmd_match) begin
					// A non-hex checksum digit outranks a mismatch, which outranks
					// a pixel run that does not fit.
					if (sum_digit_bad)
						err = tfd_pkg::ERR_NOT_HEX;
					else if (byte_sum != sent_sum)
						err = tfd_pkg::ERR_MISMATCH;
					else if (!pixels_fit_body())
						err = tfd_pkg::ERR_SHORT;
					else
						err = tfd_pkg::ERR_NONE;
					if (err == tfd_pkg::ERR_NONE)
						bad_frames = 0;
					else if (bad_frames < tfd_pkg::BAD_RUN_MAX)
						bad_frames++;
					expected_q.push_back('{tfd_pkg::KIND_STATUS, 15'd0, 16'd0, 21'sd0,
						err == tfd_pkg::ERR_NONE, err, bad_frames});
				end
				cmd_match = 1'b0;
			end else begin
				body_pos = 16'(pos + 1);
			end
		end
	endtask

	task automatic check_field(input string name, input logic signed [31:0] want,
			input logic signed [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Sender: keeps valid up until the byte is taken, then offers the next one or idles.
	// Every accepted byte is fed to the model at the edge that accepts it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_ch.valid && byte_ch.ready)
				deframe_byte(byte_ch.data_byte);
			if (!byte_ch.valid || byte_ch.ready) begin
				if (byte_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					byte_ch.valid <= 1'b1;
					byte_ch.data_byte <= byte_q.pop_front();
				end else begin
					byte_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each accepted item against the oldest expectation and then
	// decides on ready for the next cycle, honoring a requested hold-off first.
	always @(posedge clk) begin
		frame_result_t want;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected item: result_kind %0d, pixel_index %0d",
						result_ch.result_kind, result_ch.pixel_index);
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					check_field("result_kind", want.result_kind, result_ch.result_kind);
					check_field("pixel_index", want.pixel_index, result_ch.pixel_index);
					check_field("raw_value", want.raw_value, result_ch.raw_value);
					check_field("temperature_centi", want.temperature_centi,
						result_ch.temperature_centi);
					check_field("frame_good", want.frame_good, result_ch.frame_good);
					check_field("error_code", want.error_code, result_ch.error_code);
					check_field("bad_run", want.bad_run, result_ch.bad_run);
				end
			end
			if (hold_order != hold_seen) begin
				hold_seen = hold_order;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog: any accepted item on either side counts as progress.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("end of test: mismatches");
					$finish;
				end
			end
		end
	end

	// Register writes go to the block and to the model together; the block is idle.
	task automatic write_reg(input logic [1:0] index,
			input logic [tfd_pkg::CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (index)
			tfd_pkg::CFG_PIXEL_OFFSET: cfg_offset = value[11:0];
			tfd_pkg::CFG_PIXEL_COUNT: cfg_count = value[14:0];
			tfd_pkg::CFG_KELVIN_OFFSET: cfg_kelvin = value;
			default: ;
		endcase
	endtask

	task automatic write_all_regs(input logic [11:0] offset, input logic [14:0] count,
			input logic [15:0] kelvin);
		write_reg(tfd_pkg::CFG_PIXEL_OFFSET, tfd_pkg::CFG_DATA_W'(offset));
		write_reg(tfd_pkg::CFG_PIXEL_COUNT, tfd_pkg::CFG_DATA_W'(count));
		write_reg(tfd_pkg::CFG_KELVIN_OFFSET, kelvin);
	endtask

	// Waits until nothing is queued, offered or expected. The check runs on the falling
	// edge so that it sees what the last rising edge settled; the extra cycles cover
	// bytes still inside the block that make no item.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (byte_q.size() != 0 || byte_ch.valid || expected_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 10)
			return 8'("0" + v);
		return 8'(($urandom_range(1) ? "A" : "a") + v - 10);
	endfunction

	function automatic logic [7:0] non_hex_byte();
		logic [7:0] b;
		logic [4:0] digit;
		do begin
			b = 8'($urandom_range(255));
			digit = hex_digit_value(b);
		end while (digit[4]);
		return b;
	endfunction

	function automatic checksum_mode_t pick_checksum();
		int roll;
		roll = $urandom_range(9);
		if (roll == 0)
			return CK_WRONG;
		if (roll == 1)
			return CK_NOT_HEX;
		return CK_GOOD;
	endfunction

	// Every byte of stimulus goes through here so that the amount sent is known.
	task automatic queue_byte(input logic [7:0] b);
		byte_q.push_back(b);
		queued_bytes++;
	endtask

	task automatic push_sync(input int spaces);
		repeat (spaces) queue_byte(SYNC_SPACE);
		queue_byte(SYNC_HASH);
	endtask

	// Builds one whole frame: sync, four length digits, and a body of len bytes whose
	// last four are the checksum digits when the body is long enough to carry them.
	task automatic push_frame(input int len, input bit gfra, input checksum_mode_t ck,
			input fill_kind_t fill);
		logic [7:0] body[$];
		logic [15:0] sum;
		logic [7:0] digit_byte;
		int spot;
		sum = 0;
		push_sync(3 + ($urandom_range(3) == 0 ? $urandom_range(1, 3) : 0));
		for (int i = 3; i >= 0; i--) begin
			digit_byte = hex_char(len[4 * i +: 4]);
			sum += 16'(digit_byte);
			queue_byte(digit_byte);
		end
		for (int i = 0; i < len; i++) begin
			if (i < 4)
				body.push_back(CMD_TAG[i]);
			else if (fill == FILL_ONES)
				body.push_back(8'hFF);
			else if (fill == FILL_EXTREMES)
				body.push_back(((i - 4) % 4 < 2) ? 8'h00 : 8'hFF);
			else
				body.push_back(8'($urandom_range(255)));
		end
		// A foreign command differs from the tag in at least one of its bytes.
		if (!gfra && len > 0) begin
			spot = $urandom_range((len < 4 ? len : 4) - 1);
			body[spot] = body[spot] ^ 8'($urandom_range(1, 255));
		end
		if (len >= 8) begin
			for (int i = 0; i < len - 4; i++)
				sum += 16'(body[i]);
			if (ck == CK_WRONG)
				sum += 16'($urandom_range(1, 65535));
			for (int i = 0; i < 4; i++)
				body[len - 4 + i] = hex_char(sum[15 - 4 * i -: 4]);
			if (ck == CK_NOT_HEX)
				body[len - 4 + $urandom_range(3)] = non_hex_byte();
		end
		foreach (body[i])
			queue_byte(body[i]);
	endtask

	// A sync whose length field breaks off early; the offending byte may be a space or
	// a hash, which the hunt then has to take into account.
	task automatic push_broken_header();
		int pick;
		push_sync(3);
		repeat ($urandom_range(3)) queue_byte(hex_char(4'($urandom_range(15))));
		pick = $urandom_range(3);
		if (pick == 0)
			queue_byte(SYNC_SPACE);
		else if (pick == 1)
			queue_byte(SYNC_HASH);
		else
			queue_byte(non_hex_byte());
	endtask

	// Line noise between frames; hashes are swapped out so that noise never forms a
	// sync that would open a frame of random, possibly huge, length.
	task automatic push_noise(input int count);
		logic [7:0] b;
		repeat (count) begin
			b = 8'($urandom_range(255));
			queue_byte(b == SYNC_HASH ? HASH_STANDIN : b);
		end
	endtask

	// Mostly well-formed pixel frames with random content; the rest are frames whose
	// pixels run into the checksum, foreign and short frames, broken headers and noise.
	task automatic push_random_frame();
		int roll;
		int span;
		roll = $urandom_range(99);
		span = int'(cfg_offset) + 2 * int'(cfg_count);
		if (roll < 60 || (roll < 70 && span == 0)) begin
			push_frame(8 + span + $urandom_range(3), 1'b1, pick_checksum(), FILL_RANDOM);
		end else if (roll < 70) begin
			push_frame(8 + $urandom_range(span - 1), 1'b1, pick_checksum(), FILL_RANDOM);
		end else if (roll < 80) begin
			push_frame($urandom_range(4, 20), 1'b0, pick_checksum(), FILL_RANDOM);
		end else if (roll < 85) begin
			push_frame($urandom_range(7), $urandom_range(1), CK_GOOD, FILL_RANDOM);
		end else if (roll < 95) begin
			push_broken_header();
			push_noise($urandom_range(4));
		end else begin
			push_noise($urandom_range(1, 12));
		end
	endtask

	// One random phase: fresh registers while idle, then frames until the byte goal.
	task automatic random_phase(input int goal, input int send_pct, input int recv_pct,
			input bit long_hold);
		logic [15:0] kelvin;
		int target;
		wait_drained();
		case ($urandom_range(3))
			0: kelvin = tfd_pkg::RST_KELVIN_OFFSET;
			1: kelvin = 16'h8000;
			2: kelvin = 16'h0000;
			default: kelvin = 16'($urandom_range(65535));
		endcase
		write_all_regs(12'($urandom_range(9) == 0 ? $urandom_range(40) : $urandom_range(6)),
			15'($urandom_range(5)), kelvin);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		if (long_hold)
			hold_order++;
		target = queued_bytes + goal;
		while (queued_bytes < target)
			push_random_frame();
	endtask

	initial begin
		// Every input is known from time zero; the model starts in its reset state.
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = tfd_pkg::CFG_PIXEL_OFFSET;
		cfg_data = '0;
		byte_ch.valid = 1'b0;
		byte_ch.data_byte = 8'h00;
		result_ch.ready = 1'b0;
		deframe_phase = SEEK_SYNC;
		space_run = 0;
		frame_len = 0;
		body_pos = 0;
		cmd_match = 1'b0;
		byte_sum = 0;
		sent_sum = 0;
		sum_digit_bad = 1'b0;
		low_hold = 0;
		pixel_next = 0;
		bad_frames = 0;
		cfg_offset = tfd_pkg::RST_PIXEL_OFFSET;
		cfg_count = tfd_pkg::RST_PIXEL_COUNT;
		cfg_kelvin = tfd_pkg::RST_KELVIN_OFFSET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed frames under the reset registers. The default pixel run is far longer
		// than these bodies, so a pixel frame here ends with a short-body status unless
		// its checksum is bad. Also covered: a broken length field, a zero-length frame,
		// a foreign command and a body too short to be checked.
		push_frame(8, 1'b1, CK_GOOD, FILL_RANDOM);
		push_broken_header();
		push_frame(0, 1'b1, CK_GOOD, FILL_RANDOM);
		push_frame(12, 1'b0, CK_GOOD, FILL_RANDOM);
		push_frame(6, 1'b1, CK_GOOD, FILL_RANDOM);
		push_frame(8, 1'b1, CK_WRONG, FILL_RANDOM);
		push_frame(8, 1'b1, CK_NOT_HEX, FILL_RANDOM);
		wait_drained();

		// Two pixels right after the command with the lowest offset: raw values of zero
		// and all ones, a body long enough for the checksum to wrap, and a mismatch. The
		// write to the unused index must change nothing.
		write_all_regs(12'd0, 15'd2, 16'h8000);
		write_reg(CFG_UNUSED_INDEX, tfd_pkg::CFG_DATA_W'($urandom_range(65535)));
		push_frame(12, 1'b1, CK_GOOD, FILL_EXTREMES);
		push_frame(288, 1'b1, CK_GOOD, FILL_ONES);
		push_frame(12, 1'b1, CK_WRONG, FILL_RANDOM);
		wait_drained();

		// Largest offset and count: pixels can never fit, and a long run of bad frames
		// drives the bad-frame count into saturation.
		write_all_regs(12'd4095, 15'd32767, 16'h0000);
		repeat (16) push_frame(8, 1'b1, pick_checksum(), FILL_RANDOM);
		push_frame(20, 1'b1, CK_GOOD, FILL_RANDOM);
		wait_drained();

		// No pixels at all: a clean frame is good and clears the bad-frame count.
		write_all_regs(12'd0, 15'd0, 16'h7FFF);
		push_frame(8, 1'b1, CK_GOOD, FILL_RANDOM);
		push_frame(9, 1'b1, CK_GOOD, FILL_RANDOM);

		// Random part: first a nearly steady sender facing a reluctant receiver, then the
		// reverse, then both at full speed with one long receiver hold-off that backs the
		// block up into its input. Each phase boundary is a full drain of the sender.
		// The bytes still to send are spread evenly over the phases that remain.
		for (int i = 0; i < RANDOM_PHASES; i++) begin
			if (i < RANDOM_PHASES / 3)
				random_phase((TOTAL_BYTES - queued_bytes) / (RANDOM_PHASES - i),
					7, 78, 1'b0);
			else if (i < 2 * RANDOM_PHASES / 3)
				random_phase((TOTAL_BYTES - queued_bytes) / (RANDOM_PHASES - i),
					78, 7, 1'b0);
			else
				random_phase((TOTAL_BYTES - queued_bytes) / (RANDOM_PHASES - i),
					0, 0, i == 2 * RANDOM_PHASES / 3);
		end
		wait_drained();

		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
